// ===== rtl/tdt_pkg.sv =====
// ----------------------------------------------------------------------------
// tdt_pkg: shared types and constants of the timer deadline table
// mode, status and controller state codes, command and status structs
// ----------------------------------------------------------------------------
package tdt_pkg;

    localparam int unsigned TIME_W     = 48;
    localparam int unsigned PERIOD_W   = 32;
    localparam int unsigned THRESH_W   = 32;
    localparam int unsigned MODE_W     = 3;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned ID_W       = 4;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 32'd3600000;
    localparam logic [TIME_W-1:0]   TIME_ALL_ONES = {TIME_W{1'b1}};

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD     = 3'd0,
        MODE_CANCEL  = 3'd1,
        MODE_REFRESH = 3'd2,
        MODE_RESET   = 3'd3,
        MODE_POLL    = 3'd4,
        MODE_QUERY   = 3'd5,
        MODE_NOP6    = 3'd6,
        MODE_NOP7    = 3'd7
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE       = 2'd0,
        ST_NOT_ACTIVE = 2'd1,
        ST_FULL       = 2'd2,
        ST_SPARE      = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND,      // scan for earliest (and free slot on add)
        S_APPLY,     // update one slot
        S_FRONT,     // rescan after update for the front test
        S_MARK,      // poll: build expiry mask
        S_PICK,      // poll: scan earliest marked slot
        S_EMIT,      // poll: hold one expired result
        S_REARM,     // poll: re-arm or free handed-back slots
        S_RESULT     // hold single result
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic latch_in;     // capture request fields
        logic scan_start;   // clear scan registers, index to zero
        logic scan_step;    // visit one slot
        logic scan_marked;  // scan over marked slots only
        logic do_add;
        logic do_cancel;
        logic do_refresh;
        logic do_reset;
        logic mark_start;
        logic mark_step;
        logic pick_take;    // remove best from mask, count it
        logic rearm_step;
        logic set_lpt;
        logic front_eval;   // evaluate front notice after rescan
        logic clr_front;
    } tdt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic found;        // scan saw at least one candidate
        logic any_free;
        logic upd_ok;       // target slot active and update needed
        logic mask_empty;
        logic out_full;     // fifteen results handed back, this one is the sixteenth
        logic rearm_done;
    } tdt_stat_t;

endpackage

// ===== rtl/tdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// tdt_ctrl: sequencer of the timer deadline table
// steps the datapath through scans and updates, drives the handshakes
// ----------------------------------------------------------------------------
module tdt_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  tdt_pkg::mode_t    in_mode,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              emit_poll,   // output shows a poll entry
    output logic              emit_last,
    output tdt_pkg::tdt_cmd_t cmd,
    input  tdt_pkg::tdt_stat_t stat
);

    tdt_pkg::state_t state_reg, state_next;
    tdt_pkg::mode_t  mode_reg, mode_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tdt_pkg::S_IDLE;
            mode_reg  <= tdt_pkg::MODE_NOP6;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        emit_poll  = 1'b0;
        emit_last  = 1'b1;
        case (state_reg)
            tdt_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.latch_in   = 1'b1;
                    cmd.scan_start = 1'b1;
                    mode_next      = in_mode;
                    state_next     = tdt_pkg::S_FIND;
                end
            end
            tdt_pkg::S_FIND:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    case (mode_reg)
                        tdt_pkg::MODE_POLL:
                        begin
                            if (stat.found)
                            begin
                                cmd.mark_start = 1'b1;
                                state_next     = tdt_pkg::S_MARK;
                            end
                            else
                            begin
                                state_next = tdt_pkg::S_RESULT;
                            end
                        end
                        tdt_pkg::MODE_QUERY:
                        begin
                            cmd.clr_front = 1'b1;
                            state_next    = tdt_pkg::S_RESULT;
                        end
                        tdt_pkg::MODE_ADD, tdt_pkg::MODE_CANCEL,
                        tdt_pkg::MODE_REFRESH, tdt_pkg::MODE_RESET:
                            state_next = tdt_pkg::S_APPLY;
                        default:
                            state_next = tdt_pkg::S_RESULT;
                    endcase
                end
            end
            tdt_pkg::S_APPLY:
            begin
                state_next = tdt_pkg::S_RESULT;
                case (mode_reg)
                    tdt_pkg::MODE_ADD:
                    begin
                        if (stat.any_free)
                        begin
                            cmd.do_add     = 1'b1;
                            cmd.scan_start = 1'b1;
                            state_next     = tdt_pkg::S_FRONT;
                        end
                    end
                    tdt_pkg::MODE_CANCEL:  cmd.do_cancel  = 1'b1;
                    tdt_pkg::MODE_REFRESH: cmd.do_refresh = 1'b1;
                    tdt_pkg::MODE_RESET:
                    begin
                        if (stat.upd_ok)
                        begin
                            cmd.do_reset   = 1'b1;
                            cmd.scan_start = 1'b1;
                            state_next     = tdt_pkg::S_FRONT;
                        end
                    end
                    default: ;
                endcase
            end
            tdt_pkg::S_FRONT:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    cmd.front_eval = 1'b1;
                    state_next     = tdt_pkg::S_RESULT;
                end
            end
            tdt_pkg::S_MARK:
            begin
                cmd.mark_step = 1'b1;
                cmd.set_lpt   = 1'b1;
                cmd.scan_start = 1'b1;
                state_next    = tdt_pkg::S_PICK;
            end
            tdt_pkg::S_PICK:
            begin
                cmd.scan_step   = 1'b1;
                cmd.scan_marked = 1'b1;
                if (stat.scan_done)
                begin
                    if (stat.found)
                    begin
                        state_next = tdt_pkg::S_EMIT;
                    end
                    else
                    begin
                        // nothing due: one empty poll result
                        state_next = tdt_pkg::S_RESULT;
                    end
                end
            end
            tdt_pkg::S_EMIT:
            begin
                out_valid = 1'b1;
                emit_poll = 1'b1;
                emit_last = stat.mask_empty || stat.out_full;
                if (!out_stall)
                begin
                    cmd.pick_take  = 1'b1;
                    cmd.scan_start = 1'b1;
                    if (emit_last)
                        state_next = tdt_pkg::S_REARM;
                    else
                        state_next = tdt_pkg::S_PICK;
                end
            end
            tdt_pkg::S_REARM:
            begin
                cmd.rearm_step = 1'b1;
                if (stat.rearm_done)
                begin
                    state_next = tdt_pkg::S_IDLE;
                end
            end
            tdt_pkg::S_RESULT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = tdt_pkg::S_IDLE;
                end
            end
            default:
                state_next = tdt_pkg::S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_res_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (state_reg == tdt_pkg::S_EMIT || state_reg == tdt_pkg::S_RESULT))
        else $error("result shown outside a result state");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !out_valid)
        else $error("request taken while a result is pending");
    a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result dropped");
`endif

endmodule

// ===== rtl/tdt_datapath.sv =====
// ----------------------------------------------------------------------------
// tdt_datapath: slot registers, scan unit and result fields
// one slot compared per cycle against the running earliest
// ----------------------------------------------------------------------------
module tdt_datapath #(
    parameter int unsigned SLOTS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  tdt_pkg::tdt_cmd_t             cmd,
    output tdt_pkg::tdt_stat_t            stat,
    input  logic                          emit_poll,
    input  logic                          emit_last,
    input  logic [tdt_pkg::THRESH_W-1:0]  threshold,
    input  logic [tdt_pkg::MODE_W-1:0]    mode,
    input  logic [tdt_pkg::ID_W-1:0]      slot_id,
    input  logic [tdt_pkg::PERIOD_W-1:0]  period_ms,
    input  logic                          recurring,
    input  logic                          restart_now,
    input  logic [tdt_pkg::TIME_W-1:0]    now_ms,
    output logic [tdt_pkg::ID_W-1:0]      slot,
    output logic [tdt_pkg::STATUS_W-1:0]  status,
    output logic                          front_new,
    output logic [tdt_pkg::TIME_W-1:0]    remaining_ms,
    output logic                          expired_valid,
    output logic                          last
);

    localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned OW = 5;   // counts up to sixteen results
    localparam int unsigned TW = tdt_pkg::TIME_W;

    logic [SLOTS-1:0]             active_reg, active_next;
    logic [SLOTS-1:0]             repeats_reg;
    logic [tdt_pkg::PERIOD_W-1:0] period_reg [SLOTS];
    logic [TW-1:0]                deadline_reg [SLOTS];
    logic [TW-1:0]                lpt_reg;
    logic                         fnot_reg;
    logic [SLOTS-1:0]             mask_reg;
    logic [SLOTS-1:0]             taken_reg;   // slots handed back this poll

    // latched request
    logic [tdt_pkg::MODE_W-1:0]   mode_reg;
    logic [tdt_pkg::ID_W-1:0]     sid_reg;
    logic [tdt_pkg::PERIOD_W-1:0] per_reg;
    logic                         rec_reg, fnow_reg;
    logic [TW-1:0]                now_reg;

    // scan
    logic [IW-1:0] idx_reg;
    logic          found_reg;
    logic [IW-1:0] best_reg;
    logic [TW-1:0] best_dl_reg;
    logic          free_reg;
    logic [IW-1:0] free_idx_reg;
    logic [OW-1:0] nout_reg;
    logic          front_reg;
    logic [IW-1:0] tgt_reg;          // slot touched by add or reset
    logic          hit_reg;          // add placed, or cancel/refresh found its slot

    logic [IW-1:0] idx;
    logic          cand, better;
    logic          sid_ok;
    logic [IW-1:0] sidx;
    logic [TW-1:0] start_t;
    logic          roll;

    assign idx    = idx_reg;
    assign sid_ok = ({{(32-tdt_pkg::ID_W){1'b0}}, sid_reg} < 32'(SLOTS));
    assign sidx   = IW'(sid_reg);

    assign cand   = cmd.scan_marked ? mask_reg[idx] : active_reg[idx];
    assign better = !found_reg || (deadline_reg[idx] < best_dl_reg);

    assign start_t = fnow_reg ? now_reg
                   : (deadline_reg[sidx] - TW'(period_reg[sidx]));

    assign roll = (now_reg < lpt_reg)
               && ((lpt_reg - now_reg) > TW'(threshold));

    assign stat.scan_done  = (idx_reg == IW'(SLOTS - 1)) && cmd.scan_step;
    assign stat.found      = found_reg || cand;
    assign stat.any_free   = free_reg;
    assign stat.upd_ok     = sid_ok && active_reg[sidx]
                          && !(per_reg == period_reg[sidx] && !fnow_reg);
    assign stat.mask_empty = ((mask_reg & ~(SLOTS'(1) << best_reg)) == '0);
    assign stat.out_full   = (nout_reg == OW'(15));
    assign stat.rearm_done = (idx_reg == IW'(SLOTS - 1));

    always_comb
    begin
        active_next = active_reg;
        if (cmd.do_add)
            active_next[free_idx_reg] = 1'b1;
        if (cmd.do_cancel && sid_ok && active_reg[sidx])
            active_next[sidx] = 1'b0;
        if (cmd.rearm_step && taken_reg[idx] && !repeats_reg[idx])
            active_next[idx] = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= '0;
            repeats_reg  <= '0;
            lpt_reg      <= '0;
            fnot_reg     <= 1'b0;
            idx_reg      <= '0;
            found_reg    <= 1'b0;
            free_reg     <= 1'b0;
            nout_reg     <= '0;
            front_reg    <= 1'b0;
            mask_reg     <= '0;
            taken_reg    <= '0;
            mode_reg     <= '0;
            sid_reg      <= '0;
            per_reg      <= '0;
            rec_reg      <= 1'b0;
            fnow_reg     <= 1'b0;
            now_reg      <= '0;
            best_reg     <= '0;
            best_dl_reg  <= '0;
            free_idx_reg <= '0;
            tgt_reg      <= '0;
            hit_reg      <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                period_reg[i]   <= '0;
                deadline_reg[i] <= '0;
            end
        end
        else
        begin
            active_reg <= active_next;
            if (cmd.latch_in)
            begin
                mode_reg  <= mode;
                sid_reg   <= slot_id;
                per_reg   <= period_ms;
                rec_reg   <= recurring;
                fnow_reg  <= restart_now;
                now_reg   <= now_ms;
                front_reg <= 1'b0;
                nout_reg  <= '0;
                taken_reg <= '0;
                hit_reg   <= 1'b0;
            end
            if (cmd.scan_start)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
                free_reg  <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                if (idx_reg != IW'(SLOTS - 1))
                    idx_reg <= idx_reg + IW'(1);
                if (cand && better)
                begin
                    found_reg   <= 1'b1;
                    best_reg    <= idx;
                    best_dl_reg <= deadline_reg[idx];
                end
                if (!active_reg[idx] && !free_reg)
                begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= idx;
                end
            end
            else if (cmd.rearm_step)
            begin
                if (idx_reg != IW'(SLOTS - 1))
                    idx_reg <= idx_reg + IW'(1);
                if (taken_reg[idx] && repeats_reg[idx])
                    deadline_reg[idx] <= now_reg + TW'(period_reg[idx]);
            end
            if (cmd.do_add)
            begin
                repeats_reg[free_idx_reg]  <= rec_reg;
                period_reg[free_idx_reg]   <= per_reg;
                deadline_reg[free_idx_reg] <= now_reg + TW'(per_reg);
                tgt_reg                    <= free_idx_reg;
                hit_reg                    <= 1'b1;
            end
            if (cmd.do_cancel || cmd.do_refresh)
                hit_reg <= sid_ok && active_reg[sidx];
            if (cmd.do_refresh && sid_ok && active_reg[sidx])
                deadline_reg[sidx] <= now_reg + TW'(period_reg[sidx]);
            if (cmd.do_reset)
            begin
                period_reg[sidx]   <= per_reg;
                deadline_reg[sidx] <= start_t + TW'(per_reg);
                tgt_reg            <= sidx;
            end
            if (cmd.front_eval)
            begin
                // scan register does not hold the last slot yet; compare it here too
                if (((cand && better) ? idx : best_reg) == tgt_reg && !fnot_reg)
                begin
                    front_reg <= 1'b1;
                    fnot_reg  <= 1'b1;
                end
            end
            if (cmd.clr_front)
                fnot_reg <= 1'b0;
            if (cmd.mark_step)
            begin
                for (int i = 0; i < SLOTS; i++)
                    mask_reg[i] <= active_reg[i] && (roll || deadline_reg[i] <= now_reg);
            end
            if (cmd.set_lpt)
                lpt_reg <= now_reg;
            if (cmd.pick_take)
            begin
                mask_reg[best_reg]  <= 1'b0;
                taken_reg[best_reg] <= 1'b1;
                nout_reg            <= nout_reg + OW'(1);
            end
        end
    end

    // result fields
    always_comb
    begin
        slot          = '0;
        status        = tdt_pkg::ST_DONE;
        front_new     = 1'b0;
        remaining_ms  = '0;
        expired_valid = 1'b0;
        last          = emit_last;
        if (emit_poll)
        begin
            slot          = tdt_pkg::ID_W'(best_reg);
            expired_valid = 1'b1;
        end
        else
        begin
            case (tdt_pkg::mode_t'(mode_reg))
                tdt_pkg::MODE_ADD:
                begin
                    if (hit_reg)
                        slot = tdt_pkg::ID_W'(tgt_reg);
                    else
                        status = tdt_pkg::ST_FULL;
                    front_new = front_reg;
                end
                tdt_pkg::MODE_CANCEL, tdt_pkg::MODE_REFRESH:
                begin
                    if (!hit_reg)
                        status = tdt_pkg::ST_NOT_ACTIVE;
                end
                tdt_pkg::MODE_RESET:
                    front_new = front_reg;
                tdt_pkg::MODE_QUERY:
                begin
                    if (!found_reg)
                        remaining_ms = tdt_pkg::TIME_ALL_ONES;
                    else if (now_reg >= best_dl_reg)
                        remaining_ms = '0;
                    else
                        remaining_ms = best_dl_reg - now_reg;
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_out_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pick_take |-> nout_reg < OW'(16))
        else $error("more than sixteen expired results");
    a_take_marked: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pick_take |-> mask_reg[best_reg])
        else $error("handed back a slot that was not expired");
    a_add_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_add |-> !active_reg[free_idx_reg])
        else $error("add landed on an active slot");
`endif

endmodule

// ===== rtl/timer_deadline_table_unit.sv =====
// ----------------------------------------------------------------------------
// timer_deadline_table_unit: table of deadline timers with ordered expiry
// add, cancel, refresh, reset, poll and query over a small slot table
// ----------------------------------------------------------------------------
// one request at a time. each request walks the slot table one slot per
// cycle through a single compare unit. query, a poll of an empty table,
// cancel, refresh, an add to a full table and a reset that changes
// nothing walk the table once; add and a changing reset walk twice (free
// slot, then front check). poll walks once to find any active slot, marks
// the expired set, then walks the table once for every expired slot it
// hands back (up to sixteen, deadline order, ties to the lower slot), and
// closes with one walk that re-arms or frees them. a result is held while
// out_stall is high. a new request is taken only once all results of the
// previous one are gone.
// the rollover threshold port is always ready; write it only while the
// block is idle. reset value 3600000 ms.
module timer_deadline_table_unit #(
    parameter int unsigned SLOTS = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tdt_pkg::THRESH_W-1:0]      cfg_data,
    // request channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [tdt_pkg::MODE_W-1:0]        mode,
    input  logic [tdt_pkg::ID_W-1:0]          slot_id,
    input  logic [tdt_pkg::PERIOD_W-1:0]      period_ms,
    input  logic                              recurring,
    input  logic                              restart_now,
    input  logic [tdt_pkg::TIME_W-1:0]        now_ms,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tdt_pkg::ID_W-1:0]          slot,
    output logic [tdt_pkg::STATUS_W-1:0]      status,
    output logic                              front_new,
    output logic [tdt_pkg::TIME_W-1:0]        remaining_ms,
    output logic                              expired_valid,
    output logic                              last
);

    tdt_pkg::tdt_cmd_t  cmd;
    tdt_pkg::tdt_stat_t stat;
    logic               emit_poll, emit_last;
    logic [tdt_pkg::THRESH_W-1:0] thresh_reg;

    // rollover threshold, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thresh_reg <= tdt_pkg::THRESH_RESET;
        else if (cfg_valid && cfg_ready)
            thresh_reg <= cfg_data;
    end

    tdt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_mode   (tdt_pkg::mode_t'(mode)),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .emit_poll (emit_poll),
        .emit_last (emit_last),
        .cmd       (cmd),
        .stat      (stat)
    );

    tdt_datapath #(.SLOTS(SLOTS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .emit_poll     (emit_poll),
        .emit_last     (emit_last),
        .threshold     (thresh_reg),
        .mode          (mode),
        .slot_id       (slot_id),
        .period_ms     (period_ms),
        .recurring     (recurring),
        .restart_now   (restart_now),
        .now_ms        (now_ms),
        .slot          (slot),
        .status        (status),
        .front_new     (front_new),
        .remaining_ms  (remaining_ms),
        .expired_valid (expired_valid),
        .last          (last)
    );

endmodule
